/* sv/stack_machine_execute_unit_assert.svh */
// assertion macros for the stack machine execute unit
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// implication checked at every clock edge out of reset
`define SMEU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never hold out of reset
`define SMEU_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

/* sv/smeu_pkg.sv */
// shared types, codes and constants of the stack machine execute unit
package smeu_pkg;

    localparam int DATA_W    = 64;
    localparam int OP_W      = 4;
    localparam int ARGC_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int DEPTH_W   = 7;
    localparam int MSIZE_W   = 9;
    localparam int KIND_W    = 4;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 200;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int MEM_WORDS_DEF   = 256;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [MSIZE_W-1:0] MSIZE_RESET = 9'd256;

    // operation codes
    localparam logic [OP_W-1:0] OP_CONST = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_STORE = 4'd2;
    localparam logic [OP_W-1:0] OP_POP   = 4'd3;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd4;
    localparam logic [OP_W-1:0] OP_INC   = 4'd5;
    localparam logic [OP_W-1:0] OP_JGE   = 4'd6;
    localparam logic [OP_W-1:0] OP_JUMP  = 4'd7;
    localparam logic [OP_W-1:0] OP_ERROR = 4'd8;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ARGC   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDR   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RAISED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STACK  = 3'd4;

    // classified instruction kinds
    localparam logic [KIND_W-1:0] K_NOP   = 4'd0;
    localparam logic [KIND_W-1:0] K_FAULT = 4'd1;
    localparam logic [KIND_W-1:0] K_PUSH  = 4'd2;
    localparam logic [KIND_W-1:0] K_LOAD  = 4'd3;
    localparam logic [KIND_W-1:0] K_STORE = 4'd4;
    localparam logic [KIND_W-1:0] K_POP   = 4'd5;
    localparam logic [KIND_W-1:0] K_ADD   = 4'd6;
    localparam logic [KIND_W-1:0] K_INC   = 4'd7;
    localparam logic [KIND_W-1:0] K_JGE   = 4'd8;
    localparam logic [KIND_W-1:0] K_JUMP  = 4'd9;
    localparam logic [KIND_W-1:0] K_RAISE = 4'd10;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   arg;
    } instr_t;

endpackage

/* sv/smeu_front.sv */
// front end: configuration register, arity and address checks, instruction classification
module smeu_front #(
    parameter int MEM_WORDS = smeu_pkg::MEM_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [smeu_pkg::OP_W-1:0]     s_tuser,   // operation
    input  logic [smeu_pkg::S_TDATA_W-1:0] s_tdata,  // arg_count, argument, zero pad
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [smeu_pkg::MSIZE_W-1:0]  cfg_data,  // memory_size
    input  logic                          clearing,
    output logic                          q_wr_valid,
    input  logic                          q_wr_ready,
    output smeu_pkg::instr_t              q_wr_data
);

    localparam int DW = smeu_pkg::DATA_W;

    logic [smeu_pkg::MSIZE_W-1:0] msize_reg;
    logic [smeu_pkg::ARGC_W-1:0]  argc;
    logic [DW-1:0]                arg;
    logic [DW-1:0]                msize_ext;
    logic [DW-1:0]                lim;
    logic                         addr_ok;
    smeu_pkg::instr_t             ent;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msize_reg <= smeu_pkg::MSIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            msize_reg <= cfg_data;
        end
    end

    assign argc      = s_tdata[smeu_pkg::ARGC_W-1:0];
    assign arg       = s_tdata[smeu_pkg::ARGC_W +: DW];
    assign msize_ext = DW'(msize_reg);
    assign lim       = (msize_ext < DW'(MEM_WORDS)) ? msize_ext : DW'(MEM_WORDS);
    assign addr_ok   = arg < lim;

    always_comb begin
        ent.arg    = arg;
        ent.status = smeu_pkg::ST_OK;
        ent.kind   = smeu_pkg::K_NOP;
        unique case (s_tuser) inside
            smeu_pkg::OP_CONST: begin
                ent.kind = (argc != 2'd0) ? smeu_pkg::K_PUSH : smeu_pkg::K_NOP;
            end
            smeu_pkg::OP_LOAD, smeu_pkg::OP_STORE: begin
                if (argc != 2'd1) begin
                    ent.kind   = smeu_pkg::K_FAULT;
                    ent.status = smeu_pkg::ST_ARGC;
                end else if (!addr_ok) begin
                    ent.kind   = smeu_pkg::K_FAULT;
                    ent.status = smeu_pkg::ST_ADDR;
                end else begin
                    ent.kind = (s_tuser == smeu_pkg::OP_LOAD) ? smeu_pkg::K_LOAD
                                                              : smeu_pkg::K_STORE;
                end
            end
            smeu_pkg::OP_POP, smeu_pkg::OP_ADD, smeu_pkg::OP_INC: begin
                if (argc != 2'd0) begin
                    ent.kind   = smeu_pkg::K_FAULT;
                    ent.status = smeu_pkg::ST_ARGC;
                end else if (s_tuser == smeu_pkg::OP_POP) begin
                    ent.kind = smeu_pkg::K_POP;
                end else if (s_tuser == smeu_pkg::OP_ADD) begin
                    ent.kind = smeu_pkg::K_ADD;
                end else begin
                    ent.kind = smeu_pkg::K_INC;
                end
            end
            smeu_pkg::OP_JGE, smeu_pkg::OP_JUMP, smeu_pkg::OP_ERROR: begin
                if (argc != 2'd1) begin
                    ent.kind   = smeu_pkg::K_FAULT;
                    ent.status = smeu_pkg::ST_ARGC;
                end else if (s_tuser == smeu_pkg::OP_JGE) begin
                    ent.kind = smeu_pkg::K_JGE;
                end else if (s_tuser == smeu_pkg::OP_JUMP) begin
                    ent.kind = smeu_pkg::K_JUMP;
                end else begin
                    ent.kind = smeu_pkg::K_RAISE;
                end
            end
            default: begin
                ent.kind = smeu_pkg::K_NOP;
            end
        endcase
    end

    assign q_wr_data  = ent;
    assign q_wr_valid = s_tvalid && !clearing;
    assign s_tready   = q_wr_ready && !clearing;

endmodule

/* sv/smeu_queue.sv */
// short instruction queue between front end and execute sequencer
module smeu_queue #(
    parameter int DEPTH = smeu_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  smeu_pkg::instr_t wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output smeu_pkg::instr_t rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    smeu_pkg::instr_t entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign wr_ready = count_reg != CW'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = entries[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entries[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* sv/smeu_back.sv */
// execute sequencer: data stack, data memory, clearing pass and result register
module smeu_back #(
    parameter int STACK_DEPTH = smeu_pkg::STACK_DEPTH_DEF,
    parameter int MEM_WORDS   = smeu_pkg::MEM_WORDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_rd_valid,
    output logic                           q_rd_ready,
    input  smeu_pkg::instr_t               q_rd_data,
    output logic                           clearing,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [smeu_pkg::STATUS_W-1:0]  m_tuser,  // status
    output logic [smeu_pkg::M_TDATA_W-1:0] m_tdata   // raised_value, jump_taken,
                                                     // jump_offset, stack_depth, top_value
);

    localparam int DW   = smeu_pkg::DATA_W;
    localparam int DPW  = smeu_pkg::DEPTH_W;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int MA_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;

    logic [DW-1:0] stk  [STACK_DEPTH];
    logic [DW-1:0] dmem [MEM_WORDS];

    logic [1:0]                    state_reg, state_next;
    logic [MA_W-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [SP_W-1:0]               sp_reg, sp_next;
    logic [DW-1:0]                 tos_reg, tos_next;
    logic [smeu_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [DW-1:0]                 arg_reg, arg_next;
    logic                          m_valid_reg, m_valid_next;
    logic [smeu_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [DW-1:0]                 m_raised_reg, m_raised_next;
    logic                          m_taken_reg, m_taken_next;
    logic [DW-1:0]                 m_offset_reg, m_offset_next;
    logic [DPW-1:0]                m_depth_reg, m_depth_next;
    logic [DW-1:0]                 m_top_reg, m_top_next;

    logic [DW-1:0] rd_a_reg, rd_b_reg, dm_rd_reg;

    logic            stk_we, stk_re;
    logic [SA_W-1:0] stk_waddr, stk_ra, stk_rb;
    logic [DW-1:0]   stk_wdata;
    logic            dm_we, dm_re;
    logic [MA_W-1:0] dm_waddr, dm_raddr;
    logic [DW-1:0]   dm_wdata;

    logic                          out_free, full, done;
    logic [smeu_pkg::STATUS_W-1:0] res_status;
    logic [DW-1:0]                 res_raised, res_offset;
    logic                          res_taken;

    assign out_free   = !m_valid_reg || m_tready;
    assign full       = sp_reg == SP_W'(STACK_DEPTH);
    assign clearing   = state_reg == S_CLEAR;
    assign q_rd_ready = (state_reg == S_IDLE) && out_free;

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        sp_next       = sp_reg;
        tos_next      = tos_reg;
        kind_next     = kind_reg;
        arg_next      = arg_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_raised_next = m_raised_reg;
        m_taken_next  = m_taken_reg;
        m_offset_next = m_offset_reg;
        m_depth_next  = m_depth_reg;
        m_top_next    = m_top_reg;
        stk_we        = 1'b0;
        stk_waddr     = SA_W'(sp_reg - SP_W'(1));
        stk_wdata     = tos_reg;
        stk_re        = 1'b0;
        stk_ra        = SA_W'(sp_reg - SP_W'(2));
        stk_rb        = SA_W'(sp_reg - SP_W'(3));
        dm_we         = 1'b0;
        dm_waddr      = q_rd_data.arg[MA_W-1:0];
        dm_wdata      = tos_reg;
        dm_re         = 1'b0;
        dm_raddr      = q_rd_data.arg[MA_W-1:0];
        done          = 1'b0;
        res_status    = smeu_pkg::ST_OK;
        res_raised    = '0;
        res_taken     = 1'b0;
        res_offset    = '0;

        unique case (state_reg)
            S_CLEAR: begin
                dm_we    = 1'b1;
                dm_waddr = clr_cnt_reg;
                dm_wdata = '0;
                if (clr_cnt_reg == MA_W'(MEM_WORDS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (q_rd_valid && out_free) begin
                    kind_next = q_rd_data.kind;
                    arg_next  = q_rd_data.arg;
                    case (q_rd_data.kind) inside
                        smeu_pkg::K_FAULT: begin
                            done       = 1'b1;
                            res_status = q_rd_data.status;
                        end
                        smeu_pkg::K_PUSH: begin
                            done = 1'b1;
                            if (full) begin
                                res_status = smeu_pkg::ST_STACK;
                            end else begin
                                stk_we   = sp_reg != '0;
                                tos_next = q_rd_data.arg;
                                sp_next  = sp_reg + 1'b1;
                            end
                        end
                        smeu_pkg::K_LOAD: begin
                            if (full) begin
                                done       = 1'b1;
                                res_status = smeu_pkg::ST_STACK;
                            end else begin
                                dm_re      = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        smeu_pkg::K_STORE: begin
                            if (sp_reg == '0) begin
                                done       = 1'b1;
                                res_status = smeu_pkg::ST_STACK;
                            end else begin
                                dm_we      = 1'b1;
                                stk_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        smeu_pkg::K_POP: begin
                            if (sp_reg == '0) begin
                                done       = 1'b1;
                                res_status = smeu_pkg::ST_STACK;
                            end else begin
                                stk_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        smeu_pkg::K_ADD, smeu_pkg::K_JGE: begin
                            if (sp_reg < SP_W'(2)) begin
                                done       = 1'b1;
                                res_status = smeu_pkg::ST_STACK;
                            end else begin
                                stk_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        smeu_pkg::K_INC: begin
                            done = 1'b1;
                            if (sp_reg == '0) begin
                                res_status = smeu_pkg::ST_STACK;
                            end else begin
                                tos_next = tos_reg + DW'(1);
                            end
                        end
                        smeu_pkg::K_JUMP: begin
                            done       = 1'b1;
                            res_taken  = 1'b1;
                            res_offset = q_rd_data.arg;
                        end
                        smeu_pkg::K_RAISE: begin
                            done       = 1'b1;
                            res_status = smeu_pkg::ST_RAISED;
                            res_raised = q_rd_data.arg;
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                state_next = S_IDLE;
                done       = 1'b1;
                case (kind_reg) inside
                    smeu_pkg::K_LOAD: begin
                        stk_we   = sp_reg != '0;
                        tos_next = dm_rd_reg;
                        sp_next  = sp_reg + 1'b1;
                    end
                    smeu_pkg::K_STORE, smeu_pkg::K_POP: begin
                        tos_next = rd_a_reg;
                        sp_next  = sp_reg - 1'b1;
                    end
                    smeu_pkg::K_ADD: begin
                        tos_next = rd_a_reg + tos_reg;
                        sp_next  = sp_reg - 1'b1;
                    end
                    smeu_pkg::K_JGE: begin
                        res_taken  = $signed(rd_a_reg) >= $signed(tos_reg);
                        res_offset = res_taken ? arg_reg : '0;
                        tos_next   = rd_b_reg;
                        sp_next    = sp_reg - SP_W'(2);
                    end
                    default: begin
                        sp_next = sp_reg;
                    end
                endcase
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (done) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status;
            m_raised_next = res_raised;
            m_taken_next  = res_taken;
            m_offset_next = res_offset;
            m_depth_next  = DPW'(sp_next);
            m_top_next    = (sp_next != '0) ? tos_next : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg      <= tos_next;
        kind_reg     <= kind_next;
        arg_reg      <= arg_next;
        m_status_reg <= m_status_next;
        m_raised_reg <= m_raised_next;
        m_taken_reg  <= m_taken_next;
        m_offset_reg <= m_offset_next;
        m_depth_reg  <= m_depth_next;
        m_top_reg    <= m_top_next;
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            rd_a_reg <= stk[stk_ra];
            rd_b_reg <= stk[stk_rb];
        end
    end

    always_ff @(posedge aclk) begin
        if (dm_we) begin
            dmem[dm_waddr] <= dm_wdata;
        end
        if (dm_re) begin
            dm_rd_reg <= dmem[dm_raddr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_top_reg, m_depth_reg, m_offset_reg, m_taken_reg, m_raised_reg};

endmodule

/* sv/stack_machine_execute_unit.sv */
// stack machine execute unit: front end, instruction queue and execute sequencer
// Instructions enter through a two-entry queue, so the input keeps taking transfers while the
// execute sequencer works and while a result waits on the output. The sequencer ends const,
// inc, jump, error, unknown operations and any faulted instruction in its idle state; load,
// store, pop, add and jge go on to a read state, as they read the stack or data memory through
// a registered memory port. It takes a new instruction only when idle with its result
// register free. The top of stack is held in a register and the rest of the stack in a memory
// of STACK_DEPTH words. After reset a clearing pass zeroes all MEM_WORDS words of data memory,
// during which s_tready stays low; memory_size writes are taken at any time.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = smeu_pkg::STACK_DEPTH_DEF,
    parameter int MEM_WORDS   = smeu_pkg::MEM_WORDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [smeu_pkg::OP_W-1:0]      s_tuser,   // operation
    input  logic [smeu_pkg::S_TDATA_W-1:0] s_tdata,   // arg_count, argument, zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [smeu_pkg::STATUS_W-1:0]  m_tuser,   // status
    output logic [smeu_pkg::M_TDATA_W-1:0] m_tdata,   // raised_value, jump_taken,
                                                      // jump_offset, stack_depth, top_value
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [smeu_pkg::MSIZE_W-1:0]   cfg_data   // memory_size
);

`include "stack_machine_execute_unit_assert.svh"

    logic             clearing;
    logic             q_wr_valid, q_wr_ready;
    logic             q_rd_valid, q_rd_ready;
    smeu_pkg::instr_t q_wr_data, q_rd_data;

    smeu_front #(
        .MEM_WORDS(MEM_WORDS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .q_wr_valid(q_wr_valid),
        .q_wr_ready(q_wr_ready),
        .q_wr_data (q_wr_data)
    );

    smeu_queue #(
        .DEPTH(smeu_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(q_wr_valid),
        .wr_ready(q_wr_ready),
        .wr_data (q_wr_data),
        .rd_valid(q_rd_valid),
        .rd_ready(q_rd_ready),
        .rd_data (q_rd_data)
    );

    smeu_back #(
        .STACK_DEPTH(STACK_DEPTH),
        .MEM_WORDS  (MEM_WORDS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_rd_valid(q_rd_valid),
        .q_rd_ready(q_rd_ready),
        .q_rd_data (q_rd_data),
        .clearing  (clearing),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    `SMEU_ASSERT_IMPLY(a_taken_ok, m_tvalid && m_tdata[64], m_tuser == smeu_pkg::ST_OK, "jump taken with nonzero status")
    `SMEU_ASSERT_IMPLY(a_raised_status, m_tvalid && (m_tdata[63:0] != '0), m_tuser == smeu_pkg::ST_RAISED, "raised value without raised status")
    `SMEU_ASSERT_NEVER(a_no_issue_in_clear, clearing && q_rd_valid && q_rd_ready, "instruction issued during clearing pass")

endmodule

/* test/tb_stack_machine_execute_unit.sv */
// self-checking testbench for the stack machine execute unit: directed table, random streams
`timescale 1ns / 1ps

module tb_stack_machine_execute_unit;

    localparam int STACK_WORDS     = smeu_pkg::STACK_DEPTH_DEF;
    localparam int MEM_WORDS       = smeu_pkg::MEM_WORDS_DEF;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int PHASES          = 5;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 4000;

    localparam logic [smeu_pkg::DATA_W-1:0] MAX_POS    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [smeu_pkg::DATA_W-1:0] MIN_NEG    = 64'h8000_0000_0000_0000;
    localparam logic [smeu_pkg::DATA_W-1:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [smeu_pkg::DATA_W-1:0] MINUS_FIVE = 64'hFFFF_FFFF_FFFF_FFFB;
    localparam logic [smeu_pkg::OP_W-1:0]   OP_SPARE   = 4'd15;

    typedef struct packed {
        logic [smeu_pkg::STATUS_W-1:0] status;
        logic [smeu_pkg::DATA_W-1:0]   raised;
        logic                          taken;
        logic [smeu_pkg::DATA_W-1:0]   offset;
        logic [smeu_pkg::DEPTH_W-1:0]  depth;
        logic [smeu_pkg::DATA_W-1:0]   top;
    } exec_result_t;

    typedef struct packed {
        logic [smeu_pkg::OP_W-1:0]   op;
        logic [smeu_pkg::ARGC_W-1:0] argc;
        logic [smeu_pkg::DATA_W-1:0] arg;
        logic                        typed;
        exec_result_t                want;
    } step_row_t;

    localparam step_row_t DIRECTED_ROWS [25] = '{
        '{smeu_pkg::OP_POP,   2'd0, 64'd0,      1'b1,
          '{smeu_pkg::ST_STACK,  64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_ADD,   2'd0, 64'd0,      1'b1,
          '{smeu_pkg::ST_STACK,  64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_INC,   2'd0, 64'd0,      1'b1,
          '{smeu_pkg::ST_STACK,  64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_JGE,   2'd1, 64'd9,      1'b1,
          '{smeu_pkg::ST_STACK,  64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_STORE, 2'd1, 64'd0,      1'b1,
          '{smeu_pkg::ST_STACK,  64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_LOAD,  2'd2, 64'd0,      1'b1,
          '{smeu_pkg::ST_ARGC,   64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_ERROR, 2'd1, 64'd0,      1'b1,
          '{smeu_pkg::ST_RAISED, 64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_ERROR, 2'd1, MIN_NEG,    1'b1,
          '{smeu_pkg::ST_RAISED, MIN_NEG, 1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_ERROR, 2'd0, 64'd5,      1'b1,
          '{smeu_pkg::ST_ARGC,   64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_CONST, 2'd0, 64'd77,     1'b1,
          '{smeu_pkg::ST_OK,     64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_CONST, 2'd3, MAX_POS,    1'b1,
          '{smeu_pkg::ST_OK,     64'd0,   1'b0, 64'd0,      7'd1, MAX_POS}},
        '{smeu_pkg::OP_INC,   2'd0, 64'd0,      1'b1,
          '{smeu_pkg::ST_OK,     64'd0,   1'b0, 64'd0,      7'd1, MIN_NEG}},
        '{smeu_pkg::OP_CONST, 2'd1, ALL_ONES,   1'b1,
          '{smeu_pkg::ST_OK,     64'd0,   1'b0, 64'd0,      7'd2, ALL_ONES}},
        '{smeu_pkg::OP_ADD,   2'd0, 64'd0,      1'b1,
          '{smeu_pkg::ST_OK,     64'd0,   1'b0, 64'd0,      7'd1, MAX_POS}},
        '{smeu_pkg::OP_STORE, 2'd1, 64'd255,    1'b1,
          '{smeu_pkg::ST_OK,     64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_LOAD,  2'd1, 64'd256,    1'b1,
          '{smeu_pkg::ST_ADDR,   64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_LOAD,  2'd1, ALL_ONES,   1'b1,
          '{smeu_pkg::ST_ADDR,   64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_LOAD,  2'd1, 64'd255,    1'b1,
          '{smeu_pkg::ST_OK,     64'd0,   1'b0, 64'd0,      7'd1, MAX_POS}},
        '{smeu_pkg::OP_JUMP,  2'd1, MINUS_FIVE, 1'b1,
          '{smeu_pkg::ST_OK,     64'd0,   1'b1, MINUS_FIVE, 7'd1, MAX_POS}},
        '{smeu_pkg::OP_JUMP,  2'd3, 64'd3,      1'b1,
          '{smeu_pkg::ST_ARGC,   64'd0,   1'b0, 64'd0,      7'd1, MAX_POS}},
        '{smeu_pkg::OP_CONST, 2'd2, 64'd5,      1'b0, '0},
        '{smeu_pkg::OP_JGE,   2'd1, 64'd12,     1'b1,
          '{smeu_pkg::ST_OK,     64'd0,   1'b1, 64'd12,     7'd0, 64'd0}},
        '{smeu_pkg::OP_POP,   2'd1, 64'd0,      1'b1,
          '{smeu_pkg::ST_ARGC,   64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{OP_SPARE,           2'd3, ALL_ONES,   1'b1,
          '{smeu_pkg::ST_OK,     64'd0,   1'b0, 64'd0,      7'd0, 64'd0}},
        '{smeu_pkg::OP_CONST, 2'd1, MIN_NEG,    1'b0, '0}
    };

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [smeu_pkg::OP_W-1:0]        s_tuser   = '0;
    logic [smeu_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [smeu_pkg::STATUS_W-1:0]    m_tuser;
    logic [smeu_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [smeu_pkg::MSIZE_W-1:0]     cfg_data  = '0;

    logic [smeu_pkg::DATA_W-1:0]  stack_words [STACK_WORDS];
    logic [smeu_pkg::DATA_W-1:0]  memory_words [MEM_WORDS];
    int unsigned                  stack_count = 0;
    logic [smeu_pkg::MSIZE_W-1:0] memory_size_setting = smeu_pkg::MSIZE_RESET;

    exec_result_t pending_results [$];
    int           failures = 0;
    int           instructions_sent = 0;
    int           stall_count = 0;
    bit           calm = 1'b0;
    bit           hold_off_request = 1'b0;
    bit           hold_off_served = 1'b0;

    stack_machine_execute_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned address_limit();
        return (memory_size_setting > MEM_WORDS) ? MEM_WORDS : memory_size_setting;
    endfunction

    function automatic exec_result_t execute_instruction(
        input logic [smeu_pkg::OP_W-1:0]   op,
        input logic [smeu_pkg::ARGC_W-1:0] argc,
        input logic [smeu_pkg::DATA_W-1:0] arg);
        exec_result_t res;
        int unsigned  n;
        logic         addr_ok;
        res     = '0;
        n       = stack_count;
        addr_ok = arg < 64'(address_limit());
        case (op)
            smeu_pkg::OP_CONST: begin
                if (argc != 2'd0) begin
                    if (n >= STACK_WORDS) res.status = smeu_pkg::ST_STACK;
                    else begin
                        stack_words[n] = arg;
                        n++;
                    end
                end
            end
            smeu_pkg::OP_LOAD: begin
                if (argc != 2'd1) res.status = smeu_pkg::ST_ARGC;
                else if (!addr_ok) res.status = smeu_pkg::ST_ADDR;
                else if (n >= STACK_WORDS) res.status = smeu_pkg::ST_STACK;
                else begin
                    stack_words[n] = memory_words[int'(arg)];
                    n++;
                end
            end
            smeu_pkg::OP_STORE: begin
                if (argc != 2'd1) res.status = smeu_pkg::ST_ARGC;
                else if (!addr_ok) res.status = smeu_pkg::ST_ADDR;
                else if (n < 1) res.status = smeu_pkg::ST_STACK;
                else begin
                    memory_words[int'(arg)] = stack_words[n-1];
                    n--;
                end
            end
            smeu_pkg::OP_POP: begin
                if (argc != 2'd0) res.status = smeu_pkg::ST_ARGC;
                else if (n < 1) res.status = smeu_pkg::ST_STACK;
                else n--;
            end
            smeu_pkg::OP_ADD: begin
                if (argc != 2'd0) res.status = smeu_pkg::ST_ARGC;
                else if (n < 2) res.status = smeu_pkg::ST_STACK;
                else begin
                    stack_words[n-2] = stack_words[n-2] + stack_words[n-1];
                    n--;
                end
            end
            smeu_pkg::OP_INC: begin
                if (argc != 2'd0) res.status = smeu_pkg::ST_ARGC;
                else if (n < 1) res.status = smeu_pkg::ST_STACK;
                else stack_words[n-1] = stack_words[n-1] + 64'd1;
            end
            smeu_pkg::OP_JGE: begin
                if (argc != 2'd1) res.status = smeu_pkg::ST_ARGC;
                else if (n < 2) res.status = smeu_pkg::ST_STACK;
                else begin
                    if ($signed(stack_words[n-2]) >= $signed(stack_words[n-1])) begin
                        res.taken  = 1'b1;
                        res.offset = arg;
                    end
                    n -= 2;
                end
            end
            smeu_pkg::OP_JUMP: begin
                if (argc != 2'd1) res.status = smeu_pkg::ST_ARGC;
                else begin
                    res.taken  = 1'b1;
                    res.offset = arg;
                end
            end
            smeu_pkg::OP_ERROR: begin
                if (argc != 2'd1) res.status = smeu_pkg::ST_ARGC;
                else begin
                    res.status = smeu_pkg::ST_RAISED;
                    res.raised = arg;
                end
            end
            default: ;
        endcase
        stack_count = n;
        res.depth   = smeu_pkg::DEPTH_W'(n);
        res.top     = (n > 0) ? stack_words[n-1] : '0;
        return res;
    endfunction

    function automatic logic [smeu_pkg::DATA_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [smeu_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return MAX_POS;
            2: return MIN_NEG;
            3: return ALL_ONES;
            4: return 64'($urandom_range(0, 20));
            default: return random_word();
        endcase
    endfunction

    function automatic logic [smeu_pkg::DATA_W-1:0] pick_address();
        int unsigned lim;
        lim = address_limit();
        case ($urandom_range(0, 9))
            0: return 64'(lim - 1);
            1: return 64'(lim);
            2: return random_word();
            3: return {32'hFFFF_FFFF, $urandom};
            default: return 64'($urandom_range(0, lim - 1));
        endcase
    endfunction

    task automatic send_instruction(input logic [smeu_pkg::OP_W-1:0]   op,
                                    input logic [smeu_pkg::ARGC_W-1:0] argc,
                                    input logic [smeu_pkg::DATA_W-1:0] arg,
                                    input logic typed, input exec_result_t typed_want);
        exec_result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(smeu_pkg::S_TDATA_W-smeu_pkg::DATA_W-smeu_pkg::ARGC_W){1'b0}}, arg, argc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = execute_instruction(op, argc, arg);
        pending_results.push_back(typed ? typed_want : predicted);
        instructions_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_memory_size(input logic [smeu_pkg::MSIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        memory_size_setting = value;
    endtask

    task automatic fill_stack();
        while (stack_count < STACK_WORDS) begin
            if ($urandom_range(0, 3) == 0)
                send_instruction(smeu_pkg::OP_LOAD, 2'd1,
                                 64'($urandom_range(0, address_limit() - 1)), 1'b0, '0);
            else
                send_instruction(smeu_pkg::OP_CONST, 2'($urandom_range(1, 3)), pick_value(),
                                 1'b0, '0);
        end
        send_instruction(smeu_pkg::OP_CONST, 2'd1, pick_value(), 1'b0, '0);
        send_instruction(smeu_pkg::OP_LOAD, 2'd1, 64'd0, 1'b0, '0);
    endtask

    task automatic issue_random();
        int unsigned                 pick;
        logic [smeu_pkg::OP_W-1:0]   op;
        logic [smeu_pkg::ARGC_W-1:0] argc;
        logic [smeu_pkg::DATA_W-1:0] first;
        logic [smeu_pkg::DATA_W-1:0] second;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            op   = smeu_pkg::OP_W'($urandom);
            argc = smeu_pkg::ARGC_W'($urandom);
            send_instruction(op, argc, random_word(), 1'b0, '0);
        end else if (pick < 27) begin
            first = pick_value();
            case ($urandom_range(0, 3))
                0: second = first;
                1: second = first + 64'd1;
                2: second = first - 64'd1;
                default: second = pick_value();
            endcase
            send_instruction(smeu_pkg::OP_CONST, 2'($urandom_range(1, 3)), first, 1'b0, '0);
            send_instruction(smeu_pkg::OP_CONST, 2'($urandom_range(1, 3)), second, 1'b0, '0);
            send_instruction(smeu_pkg::OP_JGE, 2'd1, pick_value(), 1'b0, '0);
        end else if (pick < 37) begin
            op = $urandom_range(0, 1) ? smeu_pkg::OP_LOAD : smeu_pkg::OP_STORE;
            send_instruction(op, 2'd1, pick_address(), 1'b0, '0);
        end else begin
            op = smeu_pkg::OP_W'($urandom_range(0, 8));
            if (stack_count > 56 && $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 3))
                    0: op = smeu_pkg::OP_POP;
                    1: op = smeu_pkg::OP_ADD;
                    2: op = smeu_pkg::OP_STORE;
                    default: op = smeu_pkg::OP_JGE;
                endcase
            end
            if (stack_count < 2 && $urandom_range(0, 3) != 0) begin
                case (op) inside
                    smeu_pkg::OP_STORE, smeu_pkg::OP_POP, smeu_pkg::OP_ADD,
                    smeu_pkg::OP_INC, smeu_pkg::OP_JGE: op = smeu_pkg::OP_CONST;
                    default: ;
                endcase
            end
            case (op) inside
                smeu_pkg::OP_CONST: argc = 2'($urandom_range(1, 3));
                smeu_pkg::OP_POP, smeu_pkg::OP_ADD, smeu_pkg::OP_INC: argc = 2'd0;
                default: argc = 2'd1;
            endcase
            case (op) inside
                smeu_pkg::OP_LOAD, smeu_pkg::OP_STORE: first = pick_address();
                default: first = pick_value();
            endcase
            send_instruction(op, argc, first, 1'b0, '0);
        end
    endtask

    initial begin
        logic [smeu_pkg::MSIZE_W-1:0] size_choice;
        int                           phase_end;
        bit                           hold_off_issued;
        bit                           pause_issued;
        hold_off_issued = 1'b0;
        pause_issued    = 1'b0;
        for (int i = 0; i < MEM_WORDS; i++) memory_words[i] = '0;
        for (int i = 0; i < STACK_WORDS; i++) stack_words[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            send_instruction(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].argc, DIRECTED_ROWS[i].arg,
                             DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: size_choice = 9'd1;
                1: size_choice = smeu_pkg::MSIZE_RESET;
                2: size_choice = smeu_pkg::MSIZE_W'($urandom_range(2, 255));
                3: size_choice = 9'd255;
                default: size_choice = smeu_pkg::MSIZE_W'($urandom_range(1, 256));
            endcase
            write_memory_size(size_choice);
            calm = (phase == PHASES - 1);
            phase_end = instructions_sent + ITEMS_PER_PHASE;
            if (phase == 1 || phase == 3) fill_stack();
            while (instructions_sent < phase_end) begin
                if (phase == 2 && !hold_off_issued
                    && instructions_sent >= phase_end - 100) begin
                    hold_off_request = 1'b1;
                    hold_off_issued  = 1'b1;
                end
                if (phase == 3 && !pause_issued && instructions_sent >= phase_end - 70) begin
                    wait_drained();
                    pause_issued = 1'b1;
                end
                issue_random();
            end
        end

        wait_drained();
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        @(posedge aclk);
        forever begin
            if (hold_off_request && !hold_off_served) begin
                m_tready <= 1'b0;
                for (int k = 0; k < HOLD_OFF_CYCLES; k++) @(posedge aclk);
                hold_off_served = 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    task automatic check_field(input string name, input logic [smeu_pkg::DATA_W-1:0] want,
                               input logic [smeu_pkg::DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        exec_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with status %0d arrived with nothing outstanding", m_tuser);
                failures++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 64'(want.status), 64'(m_tuser));
                check_field("raised_value", want.raised, m_tdata[63:0]);
                check_field("jump_taken", 64'(want.taken), 64'(m_tdata[64]));
                check_field("jump_offset", want.offset, m_tdata[128:65]);
                check_field("stack_depth", 64'(want.depth), 64'(m_tdata[135:129]));
                check_field("top_value", want.top, m_tdata[199:136]);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
